// File: hw/rtl/swsc_pkg.sv
// Shared types and constants for the sliding window sender control block.
// No dependencies; every other file of the block uses this package.
`default_nettype none
package swsc_pkg;

  localparam int TOTAL_W = 40;
  localparam int WIN_W   = 6;
  localparam int SEQ_W   = 31;
  localparam int LEN_O_W = 11;
  localparam int NUM_W   = 32;
  localparam int DUP_W   = 8;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;

  localparam int MAX_WINDOW_DEF    = 63;
  localparam int PAYLOAD_BYTES_DEF = 1400;

  localparam logic [WIN_W-1:0] INIT_WINDOW_RST = 6'd24;
  localparam logic [WIN_W-1:0] INIT_THRESH_RST = 6'd40;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLY   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACK = 2'd1;

  localparam logic [CIDX_W-1:0] CFG_XFER_BYTES  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_WINDOW = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INIT_THRESH = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [KIND_W-1:0]       ack_kind;
    logic signed [NUM_W-1:0] ack_number;
  } in_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   send_sequence;
    logic [LEN_O_W-1:0] send_length;
    logic               is_resend;
    logic [WIN_W-1:0]   window_now;
    logic [WIN_W-1:0]   threshold_now;
    logic               transfer_done;
    logic               last_of_event;
  } out_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/swsc_if.sv
// Valid/ready channel interfaces for the event input and the send command output.
// Depends on swsc_pkg for the word types.
`default_nettype none
interface swsc_in_if;
  logic               valid;
  logic               ready;
  swsc_pkg::in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface swsc_out_if;
  logic                valid;
  logic                ready;
  swsc_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sliding_window_sender_control.sv
// Top level of the sliding window sender control block.
// Depends on swsc_pkg and the channel interfaces in swsc_if.sv.
//
// Usage: events (start, timeout, reply) arrive as words on in_ch; each event
// produces one or more send command words on out_ch, the last one flagged by
// last_of_event. An event with nothing to send yields a single status word
// with send_length 0. Registers are written through cfg_we, cfg_index and
// cfg_wdata while the block is idle; the session byte count is latched at start.
// Steps: after acceptance an event updates the state (ST_EVAL) and sizes the
// free window (ST_ROOM); when it resends the oldest packet it then computes
// the length (ST_MUL multiply, then ST_LEN subtract); then it emits a word per
// new packet (ST_SEND), or one status word when it sends nothing at all.
// One shared subtractor sizes the free window, the resent length and each new
// packet.
// in_ch.ready is high only while no event is in progress. A word waits in the
// output register while out_ch.ready is low and the sequencer holds; the
// next event is accepted while the last word of the previous one waits.
// Reset clears the window state to the register reset values; transfer_done
// is 1 in any status word before the first start.
`default_nettype none
module sliding_window_sender_control #(
  parameter int MAX_WINDOW = swsc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [swsc_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [swsc_pkg::TOTAL_W-1:0]  cfg_wdata,
  swsc_in_if.sink                            in_ch,
  swsc_out_if.source                         out_ch
);
  import swsc_pkg::*;

  localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
  localparam int LEN_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int PW    = SEQ_W + LEN_W;
  localparam int CMP_W = (PW > TOTAL_W) ? PW : TOTAL_W;

  localparam logic [CMP_W-1:0] PAY_C = CMP_W'(PAYLOAD_BYTES);
  localparam logic [WIN_W-1:0] MAXW_C = WIN_W'(MAX_WINDOW);

  typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_ROOM, ST_MUL, ST_LEN, ST_SEND} state_t;
  typedef enum logic [1:0] {PH_SLOW, PH_TIMEOUT, PH_RECOVERY} phase_t;

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic [WIN_W-1:0]        iwin_r, iwin_nxt;
  logic [WIN_W-1:0]        ithr_r, ithr_nxt;
  logic [SEQ_W-1:0]        next_r, next_nxt;
  logic [SEQ_W-1:0]        old_r, old_nxt;
  logic [TOTAL_W-1:0]      unsent_r, unsent_nxt;
  logic [TOTAL_W-1:0]      session_r, session_nxt;
  logic [WIN_W-1:0]        win_r, win_nxt;
  logic [WIN_W-1:0]        thr_r, thr_nxt;
  logic [DUP_W-1:0]        dup_r, dup_nxt;
  in_word_t                ev_r, ev_nxt;
  logic                    resend_r, resend_nxt;
  logic                    send_r, send_nxt;
  logic [WIN_W-1:0]        room_r, room_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic                    out_vld_r, out_vld_nxt;
  out_word_t               out_r, out_nxt;

  logic [CMP_W-1:0]        sub_a, sub_b, sub_d;
  logic                    sub_borrow;
  logic                    flying;
  logic                    can_emit;
  logic                    num_ge_old, num_is_dup, is_ack;
  logic [DUP_W-1:0]        dup_inc;
  logic [LEN_W-1:0]        len_w;
  logic                    has_new, last_new;

  assign {sub_borrow, sub_d} = {1'b0, sub_a} - {1'b0, sub_b};
  assign flying     = (SEQ_W'(next_r - old_r) != '0);
  assign can_emit   = !out_vld_r || out_ch.ready;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_r;

  assign is_ack     = (ev_r.ack_kind == KIND_ACK);
  assign num_ge_old = !ev_r.ack_number[NUM_W-1] &&
                      (ev_r.ack_number[SEQ_W-1:0] >= old_r);
  assign num_is_dup = (old_r == '0) ? (ev_r.ack_number == '1) :
                      (!ev_r.ack_number[NUM_W-1] &&
                       (ev_r.ack_number[SEQ_W-1:0] == old_r - 1'b1));
  assign dup_inc    = (dup_r == '1) ? dup_r : dup_r + 1'b1;
  assign has_new    = (room_r != '0) && (unsent_r != '0);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    total_nxt   = total_r;
    iwin_nxt    = iwin_r;
    ithr_nxt    = ithr_r;
    next_nxt    = next_r;
    old_nxt     = old_r;
    unsent_nxt  = unsent_r;
    session_nxt = session_r;
    win_nxt     = win_r;
    thr_nxt     = thr_r;
    dup_nxt     = dup_r;
    ev_nxt      = ev_r;
    resend_nxt  = resend_r;
    send_nxt    = send_r;
    room_nxt    = room_r;
    prod_nxt    = prod_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_nxt     = out_r;
    sub_a       = CMP_W'(unsent_r);
    sub_b       = PAY_C;
    len_w       = '0;
    last_new    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_XFER_BYTES:  total_nxt = cfg_wdata;
        CFG_INIT_WINDOW: iwin_nxt  = cfg_wdata[WIN_W-1:0];
        CFG_INIT_THRESH: ithr_nxt  = cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ev_nxt    = in_ch.payload;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        resend_nxt = 1'b0;
        send_nxt   = 1'b0;
        state_nxt  = ST_ROOM;
        case (ev_r.operation)
          OP_START: begin
            session_nxt = total_r;
            unsent_nxt  = total_r;
            next_nxt    = '0;
            old_nxt     = '0;
            win_nxt     = iwin_r;
            thr_nxt     = ithr_r;
            dup_nxt     = '0;
            phase_nxt   = PH_SLOW;
            send_nxt    = 1'b1;
          end
          OP_TIMEOUT: begin
            phase_nxt  = PH_TIMEOUT;
            thr_nxt    = win_r >> 1;
            win_nxt    = iwin_r;
            dup_nxt    = '0;
            resend_nxt = flying;
          end
          OP_REPLY: begin
            send_nxt = 1'b1;
            if (is_ack && flying && num_ge_old) begin
              old_nxt = (ev_r.ack_number[SEQ_W-1:0] >= next_r) ? next_r :
                        ev_r.ack_number[SEQ_W-1:0] + 1'b1;
              if (phase_r == PH_RECOVERY) win_nxt = iwin_r;
              phase_nxt = PH_SLOW;
              dup_nxt   = '0;
            end else if (is_ack && flying && num_is_dup) begin
              dup_nxt = dup_inc;
              if (phase_r == PH_RECOVERY) begin
                if (win_r < MAXW_C) win_nxt = win_r + 1'b1;
              end else if (dup_inc == DUP_W'(3)) begin
                thr_nxt    = (win_r >> 1) + 1'b1;
                win_nxt    = iwin_r;
                phase_nxt  = PH_RECOVERY;
                resend_nxt = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_ROOM: begin
        sub_a    = CMP_W'(win_r);
        sub_b    = CMP_W'(SEQ_W'(next_r - old_r));
        room_nxt = (send_r && !sub_borrow) ? sub_d[WIN_W-1:0] : '0;
        state_nxt = resend_r ? ST_MUL : ST_SEND;
      end
      ST_MUL: begin
        prod_nxt  = PW'(old_r) * PW'(PAYLOAD_BYTES);
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        sub_a = CMP_W'(session_r);
        sub_b = CMP_W'(prod_r);
        if (sub_borrow || sub_d == '0) len_w = '0;
        else if (sub_d < PAY_C)        len_w = sub_d[LEN_W-1:0];
        else                           len_w = PAY_C[LEN_W-1:0];
        if (can_emit) begin
          out_vld_nxt           = 1'b1;
          out_nxt.send_sequence = old_r;
          out_nxt.send_length   = LEN_O_W'(len_w);
          out_nxt.is_resend     = 1'b1;
          out_nxt.window_now    = win_r;
          out_nxt.threshold_now = thr_r;
          out_nxt.transfer_done = 1'b0;
          out_nxt.last_of_event = !has_new;
          state_nxt             = has_new ? ST_SEND : ST_IDLE;
        end
      end
      ST_SEND: begin
        sub_a = CMP_W'(unsent_r);
        sub_b = PAY_C;
        if (sub_borrow) len_w = unsent_r[LEN_W-1:0];
        else            len_w = PAY_C[LEN_W-1:0];
        last_new = (room_r == WIN_W'(1)) || sub_borrow || (sub_d == '0);
        if (can_emit) begin
          out_vld_nxt           = 1'b1;
          out_nxt.is_resend     = 1'b0;
          out_nxt.window_now    = win_r;
          out_nxt.threshold_now = thr_r;
          out_nxt.send_sequence = next_r;
          if (has_new) begin
            out_nxt.send_length   = LEN_O_W'(len_w);
            out_nxt.transfer_done = 1'b0;
            out_nxt.last_of_event = last_new;
            unsent_nxt = sub_borrow ? '0 : sub_d[TOTAL_W-1:0];
            next_nxt   = next_r + 1'b1;
            room_nxt   = room_r - 1'b1;
            state_nxt  = last_new ? ST_IDLE : ST_SEND;
          end else begin
            out_nxt.send_length   = '0;
            out_nxt.transfer_done = (unsent_r == '0) && !flying;
            out_nxt.last_of_event = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ev_r     <= ev_nxt;
    resend_r <= resend_nxt;
    send_r   <= send_nxt;
    room_r   <= room_nxt;
    prod_r   <= prod_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      phase_r   <= PH_SLOW;
      total_r   <= '0;
      iwin_r    <= INIT_WINDOW_RST;
      ithr_r    <= INIT_THRESH_RST;
      next_r    <= '0;
      old_r     <= '0;
      unsent_r  <= '0;
      session_r <= '0;
      win_r     <= INIT_WINDOW_RST;
      thr_r     <= INIT_THRESH_RST;
      dup_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      phase_r   <= phase_nxt;
      total_r   <= total_nxt;
      iwin_r    <= iwin_nxt;
      ithr_r    <= ithr_nxt;
      next_r    <= next_nxt;
      old_r     <= old_nxt;
      unsent_r  <= unsent_nxt;
      session_r <= session_nxt;
      win_r     <= win_nxt;
      thr_r     <= thr_nxt;
      dup_r     <= dup_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/swsc_checker.sv
// Port-level checks for the sliding window sender control block, and the bind
// that attaches them. Depends on swsc_pkg and the top level.
`default_nettype none
module swsc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire swsc_pkg::out_word_t out_payload
);
  import swsc_pkg::*;

  // A waiting word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output word changed while stalled");

  // An accepted event keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted event");

  // A resend means a packet is outstanding, so the transfer cannot be done.
  a_resend_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.is_resend |-> !out_payload.transfer_done)
    else $error("resend word flagged as transfer done");

  // A status word is the only word of its event and is always flagged last.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.is_resend && (out_payload.send_length == '0)
      |-> out_payload.last_of_event)
    else $error("status word not flagged last");

endmodule

bind sliding_window_sender_control swsc_checker u_swsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
`default_nettype wire
